>>> design/ssm_pkg.sv
// ssm_pkg: shared constants and types of the sorted set membership block
// used by ssm_cell and sorted_set_membership; no dependencies
`timescale 1ns / 1ps

package ssm_pkg;

  // default table depth and fixed field widths
  localparam int unsigned DefCapacity = 64;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned ReqW        = 2;
  localparam int unsigned CountOutW   = 7;
  localparam int unsigned OutDataW    = 16;

  // request kinds; the fourth code changes nothing but still gets an answer word
  typedef enum logic [ReqW-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2
  } ssm_req_e;

  // broadcast from the control to every cell
  typedef struct packed {
    logic              load;
    logic              query;
    logic [ValueW-1:0] value;
  } ssm_bcast_t;

  // what a cell hands to its right-hand neighbour
  typedef struct packed {
    logic              occ;
    logic              gt;
    logic [ValueW-1:0] data;
  } ssm_link_t;

endpackage

>>> design/ssm_cell.sv
// ssm_cell: one slot of the sorted chain, holds one entry
// depends on ssm_pkg
`timescale 1ns / 1ps

module ssm_cell
  import ssm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ssm_bcast_t bcast_i,
  input  logic       occ_i,
  input  ssm_link_t  prev_i,
  output ssm_link_t  next_o,
  output logic       match_o
);

  logic [ValueW-1:0] data_q, data_d;
  logic              match_q;
  logic              gt;
  logic              take_prev;
  logic              take_new;

  // entry lies above the broadcast value
  assign gt = occ_i && ($signed(data_q) > $signed(bcast_i.value));

  // shift right behind a larger neighbour, or take the new value at its place
  assign take_prev = bcast_i.load && prev_i.gt;
  assign take_new  = bcast_i.load && !prev_i.gt && prev_i.occ && (gt || !occ_i);

  always_comb begin
    data_d = data_q;
    if (take_prev) begin
      data_d = prev_i.data;
    end else if (take_new) begin
      data_d = bcast_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // per-slot key compare, registered and held until the next query
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (bcast_i.query) begin
      match_q <= occ_i && (data_q == bcast_i.value);
    end
  end

  assign next_o.occ  = occ_i;
  assign next_o.gt   = gt;
  assign next_o.data = data_q;
  assign match_o     = match_q;

endmodule

>>> design/sorted_set_membership.sv
// sorted_set_membership: sorted table in a chain of cells with membership query
// depends on ssm_pkg and ssm_cell
`timescale 1ns / 1ps
//
//  port group   dir  contents
//  s_axis_*     in   tuser = req_type, tdata = item_value
//  m_axis_*     out  tdata = found, rejected, entry_count
//
//  On the accept cycle an item updates the cell chain or registers every
//  slot's key compare; once the output register is free, the compare bits
//  are reduced into it, and no new item is taken until that has happened.
//  Reset empties the table at once through the fill count; entries need no
//  clearing. A stalled output holds its word while the next item is taken.

module sorted_set_membership
  import ssm_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ValueW-1:0]   s_axis_tdata_i,   // [31:0] item_value
  input  logic [ReqW-1:0]     s_axis_tuser_i,   // [1:0] req_type
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // [0] found, [1] rejected, [8:2] entry_count
);

  localparam int unsigned CountW = $clog2(CAPACITY + 1);

  logic [CountW-1:0]    count_q, count_d;
  logic                 busy_q;
  logic                 pend_query_q;
  logic                 pend_rej_q;
  logic                 out_valid_q;
  logic                 out_found_q;
  logic                 out_rej_q;
  logic [CountOutW-1:0] out_count_q;

  logic                 in_acc;
  logic                 move;
  logic                 full;
  logic                 is_load;
  logic                 is_query;
  logic                 is_clear;
  ssm_bcast_t           bcast;
  logic [CAPACITY-1:0]  occ;
  logic [CAPACITY-1:0]  match;
  ssm_link_t            link [CAPACITY+1];
  logic [CountW+CountOutW-1:0] count_ext;

  // request decode
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign is_load  = s_axis_tuser_i == REQ_LOAD;
  assign is_query = s_axis_tuser_i == REQ_QUERY;
  assign is_clear = s_axis_tuser_i == REQ_CLEAR;
  assign full     = count_q == CountW'(CAPACITY);

  assign bcast.load  = in_acc && is_load && !full;
  assign bcast.query = in_acc && is_query;
  assign bcast.value = s_axis_tdata_i;

  // chain of cells, head sees an occupied slot below every value
  assign link[0].occ  = 1'b1;
  assign link[0].gt   = 1'b0;
  assign link[0].data = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = count_q > CountW'(i);
    ssm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .bcast_i (bcast),
      .occ_i   (occ[i]),
      .prev_i  (link[i]),
      .next_o  (link[i+1]),
      .match_o (match[i])
    );
  end

  // fill count
  always_comb begin
    count_d = count_q;
    if (bcast.load) begin
      count_d = count_q + CountW'(1);
    end else if (in_acc && is_clear) begin
      count_d = '0;
    end
  end

  assign s_axis_tready_o = !busy_q;
  assign move            = busy_q && (!out_valid_q || m_axis_tready_i);
  assign count_ext       = {{CountOutW{1'b0}}, count_q};

  // control and pending item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      busy_q       <= 1'b0;
      pend_query_q <= 1'b0;
      pend_rej_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        busy_q       <= 1'b1;
        pend_query_q <= is_query;
        pend_rej_q   <= is_load && full;
      end else if (move) begin
        busy_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
      out_rej_q   <= 1'b0;
      out_count_q <= '0;
    end else begin
      if (move) begin
        out_valid_q <= 1'b1;
        out_found_q <= pend_query_q && (|match);
        out_rej_q   <= pend_rej_q;
        out_count_q <= count_ext[CountOutW-1:0];
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-CountOutW-2){1'b0}}, out_count_q, out_rej_q, out_found_q};

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(CAPACITY))
    else $error("fill count above capacity");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_clear) |=> (count_q == '0))
    else $error("clear left entries behind");

  a_full_load_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_load && full) |=> $stable(count_q))
    else $error("rejected load changed the count");

  a_rej_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_rej_q && out_found_q))
    else $error("word both found and rejected");

endmodule

>>> sim/tb.sv
// tb: self-checking bench for sorted_set_membership, directed rows then random episodes
// depends on ssm_pkg and sorted_set_membership; keeps its own shadow of the stored set
`timescale 1ns / 1ps

module tb;
  import ssm_pkg::*;

  localparam int unsigned Capacity    = DefCapacity;
  localparam int unsigned ItemTarget  = 1800;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumRows     = 21;

  // the fourth request code, which leaves the table unchanged but is still answered
  localparam logic [ReqW-1:0]   ReqNone = 2'd3;
  localparam logic [ValueW-1:0] MinVal  = 32'h8000_0000;
  localparam logic [ValueW-1:0] MaxVal  = 32'h7FFF_FFFF;

  typedef struct packed {
    logic                 found;
    logic                 rejected;
    logic [CountOutW-1:0] entry_count;
  } answer_t;

  typedef struct packed {
    logic [ReqW-1:0]   req;
    logic [ValueW-1:0] value;
    logic              typed;
    answer_t           ans;
  } stim_row_t;

  logic                clk     = 1'b0;
  logic                rst_n   = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [ValueW-1:0]   s_data  = '0;
  logic [ReqW-1:0]     s_user  = '0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;

  // shadow of the stored set; only membership is visible, so arrival order is kept
  logic [ValueW-1:0] shadow_set [Capacity];
  int unsigned       shadow_fill = 0;

  answer_t     awaited_answers[$];
  int unsigned sent_items    = 0;
  int          mismatches    = 0;
  bit          tx_fast       = 1'b0;
  bit          rx_fast       = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned holds_granted = 0;
  int unsigned idle_cycles   = 0;

  // directed rows: typed answers only where they are obvious
  stim_row_t directed_rows [NumRows] = '{
    '{REQ_QUERY, 32'd0,           1'b1, '{1'b0, 1'b0, 7'd0}},
    '{REQ_LOAD,  MaxVal,          1'b1, '{1'b0, 1'b0, 7'd1}},
    '{REQ_LOAD,  MinVal,          1'b1, '{1'b0, 1'b0, 7'd2}},
    '{REQ_LOAD,  32'd0,           1'b1, '{1'b0, 1'b0, 7'd3}},
    '{REQ_QUERY, MinVal,          1'b1, '{1'b1, 1'b0, 7'd3}},
    '{REQ_QUERY, MaxVal,          1'b1, '{1'b1, 1'b0, 7'd3}},
    '{REQ_QUERY, 32'hFFFF_FFFF,   1'b1, '{1'b0, 1'b0, 7'd3}},
    '{REQ_LOAD,  32'd0,           1'b1, '{1'b0, 1'b0, 7'd4}},
    '{REQ_QUERY, 32'd0,           1'b1, '{1'b1, 1'b0, 7'd4}},
    '{ReqNone,   32'hFFFF_FFFF,   1'b1, '{1'b0, 1'b0, 7'd4}},
    '{REQ_LOAD,  32'hFFFF_FFFF,   1'b0, '0},
    '{REQ_QUERY, 32'hFFFF_FFFF,   1'b0, '0},
    '{REQ_QUERY, 32'd1,           1'b0, '0},
    '{REQ_QUERY, 32'h7FFF_FFFE,   1'b0, '0},
    '{REQ_CLEAR, 32'h5A5A_5A5A,   1'b1, '{1'b0, 1'b0, 7'd0}},
    '{REQ_QUERY, 32'd0,           1'b1, '{1'b0, 1'b0, 7'd0}},
    '{REQ_LOAD,  32'h0000_3039,   1'b0, '0},
    '{REQ_LOAD,  32'h0000_3039,   1'b0, '0},
    '{REQ_QUERY, 32'h0000_3039,   1'b0, '0},
    '{ReqNone,   MinVal,          1'b0, '0},
    '{REQ_CLEAR, MaxVal,          1'b1, '{1'b0, 1'b0, 7'd0}}
  };

  sorted_set_membership #(
    .CAPACITY(Capacity)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // answer of one request, applied to the shadow set
  function automatic void predict_answer(input logic [ReqW-1:0] req,
                                         input logic [ValueW-1:0] value,
                                         output answer_t ans);
    ans = '0;
    case (req)
      REQ_LOAD: begin
        if (shadow_fill >= Capacity) begin
          ans.rejected = 1'b1;
        end else begin
          shadow_set[shadow_fill] = value;
          shadow_fill++;
        end
      end
      REQ_QUERY: begin
        for (int i = 0; i < shadow_fill; i++)
          if (shadow_set[i] == value) ans.found = 1'b1;
      end
      REQ_CLEAR: shadow_fill = 0;
      default: ;
    endcase
    ans.entry_count = CountOutW'(shadow_fill);
  endfunction

  // keys biased towards stored values, near misses, small numbers and extremes
  function automatic logic [ValueW-1:0] pick_value();
    int unsigned r;
    int          s;
    r = $urandom_range(0, 99);
    if (r < 35 && shadow_fill != 0) return shadow_set[$urandom_range(0, shadow_fill - 1)];
    if (r < 45 && shadow_fill != 0) return shadow_set[$urandom_range(0, shadow_fill - 1)] + 1;
    if (r < 60) begin
      s = int'($urandom_range(0, 6)) - 3;
      return ValueW'(s);
    end
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0:       return MinVal;
        1:       return MaxVal;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // offer one request word and record its answer once taken
  task automatic send_request(input logic [ReqW-1:0] req, input logic [ValueW-1:0] value,
                              input logic typed, input answer_t typed_ans);
    int      gap;
    answer_t ans;
    gap = tx_fast ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= req;
    s_data  <= value;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    predict_answer(req, value, ans);
    awaited_answers.insert(awaited_answers.size(), typed ? typed_ans : ans);
    if (req != ReqNone) sent_items++;
  endtask

  // stop offering until every answer is back
  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk);
    while (awaited_answers.size() != 0) @(posedge clk);
  endtask

  // stimulus: reset, directed rows, then random episodes
  initial begin : request_source
    answer_t     none;
    int unsigned kind;
    int unsigned len;
    int unsigned r;
    int unsigned loads;
    int unsigned target;
    bit          first;
    none  = '0;
    first = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].ans);
    wait_drained();

    while (sent_items < ItemTarget) begin
      kind    = first ? 0 : $urandom_range(0, 9);
      tx_fast = first || ($urandom_range(0, 3) == 0);
      // long receiver hold while words keep coming
      if (first) hold_requests++;
      if (kind < 3) begin
        // fill past capacity so loads get rejected
        send_request(REQ_CLEAR, $urandom, 1'b0, none);
        target = Capacity + $urandom_range(1, 4);
        loads  = 0;
        while (loads < target) begin
          if ($urandom_range(0, 3) == 0) begin
            send_request(REQ_QUERY, pick_value(), 1'b0, none);
          end else begin
            send_request(REQ_LOAD, pick_value(), 1'b0, none);
            loads++;
          end
        end
        send_request(REQ_QUERY, pick_value(), 1'b0, none);
      end else if (kind < 8) begin
        // mixed traffic
        len = $urandom_range(20, 80);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 50)      send_request(REQ_LOAD, pick_value(), 1'b0, none);
          else if (r < 90) send_request(REQ_QUERY, pick_value(), 1'b0, none);
          else if (r < 93) send_request(REQ_CLEAR, $urandom, 1'b0, none);
          else             send_request(ReqNone, $urandom, 1'b0, none);
        end
      end else begin
        // mostly lookups
        len = $urandom_range(20, 60);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 15)      send_request(REQ_LOAD, pick_value(), 1'b0, none);
          else if (r < 95) send_request(REQ_QUERY, pick_value(), 1'b0, none);
          else             send_request(ReqNone, $urandom, 1'b0, none);
        end
      end
      if (first || $urandom_range(0, 2) == 0) wait_drained();
      first = 1'b0;
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver: random stalls per word, one long hold on request
  initial begin : answer_sink
    int stall;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (holds_granted != hold_requests) begin
        m_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        holds_granted++;
      end
      if ($urandom_range(0, 63) == 0) rx_fast = !rx_fast;
      stall = rx_fast ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_ready <= 1'b1;
      @(posedge clk);
      while (!m_valid) @(posedge clk);
    end
  end

  // compare each output word with the oldest awaited answer
  always @(posedge clk) begin : answer_check
    answer_t want;
    if (m_valid && m_ready) begin
      if (awaited_answers.size() == 0) begin
        $error("word with no answer awaited: %h", m_data);
        mismatches++;
      end else begin
        want = awaited_answers.pop_front();
        if (m_data[0] !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, m_data[0]);
          mismatches++;
        end
        if (m_data[1] !== want.rejected) begin
          $error("rejected: expected %0d, got %0d", want.rejected, m_data[1]);
          mismatches++;
        end
        if (m_data[8:2] !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, m_data[8:2]);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin : stall_watch
    if (rst_n) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
